@@ rtl/nfha_pkg.sv @@
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and constants for the next-fit handle allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

  localparam int HANDLE_W = 8;
  localparam int GRANT_W  = 6;
  localparam int STATUS_W = 2;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [HANDLE_W-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the accepted input word
    logic eval;        // resolve a request that needs no scan
    logic scan_start;  // load scan pointer and step count
    logic scan_step;   // test one slot
    logic out_load;    // move result into the output register
  } nfha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;   // check request with handle 0, in range
    logic scan_done;   // free slot found or circle complete
    logic out_free;    // output register can take a word this cycle
  } nfha_stat_t;

endpackage

@@ rtl/nfha_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfha_ctrl
// Request sequencer: accept, evaluate, scan, hand off result.
// ----------------------------------------------------------------------------
module nfha_ctrl import nfha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  nfha_stat_t stat,
  output nfha_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/nfha_datapath.sv @@
// ----------------------------------------------------------------------------
// nfha_datapath
// Used-mark bitmap, next-fit scan pointer and result/output registers.
// ----------------------------------------------------------------------------
module nfha_datapath import nfha_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_data,
  input  nfha_cmd_t  cmd,
  output nfha_stat_t stat,
  input  logic       out_ready,
  output logic       out_valid,
  output out_word_t  out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] CNT_INIT = IDX_W'(SLOTS - 2);
  localparam logic [HANDLE_W:0] SLOTS_X = (HANDLE_W + 1)'(SLOTS);

  in_word_t         req_r;
  logic [SLOTS-1:0] used_r;
  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] cnt_r;
  out_word_t        res_r;
  out_word_t        out_r;
  logic             out_valid_r;

  logic             bad;
  logic             hzero;
  logic [IDX_W-1:0] hidx;
  logic [IDX_W-1:0] first_idx;
  logic             hit;
  logic             last_step;

  assign bad       = ({1'b0, req_r.handle} >= SLOTS_X);
  assign hzero     = (req_r.handle == '0);
  assign hidx      = req_r.handle[IDX_W-1:0];
  // next-fit start: slot after last grant, wrapping past 0
  assign first_idx = (last_r == LAST_IDX) ? IDX_W'(1) : last_r + IDX_W'(1);
  assign hit       = !used_r[ptr_r];
  assign last_step = (cnt_r == '0);

  assign stat.need_scan = !bad && (req_r.operation == OP_CHECK) && hzero;
  assign stat.scan_done = hit || last_step;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.scan_start) begin
      ptr_r <= first_idx;
      cnt_r <= CNT_INIT;
    end else if (cmd.scan_step) begin
      ptr_r <= (ptr_r == LAST_IDX) ? IDX_W'(1) : ptr_r + IDX_W'(1);
      cnt_r <= cnt_r - IDX_W'(1);
    end
    if (cmd.eval) begin
      if (bad) begin
        res_r <= '{granted: '0, status: ST_BAD};
      end else begin
        res_r <= '{granted: GRANT_W'(req_r.handle), status: ST_OK};
      end
    end else if (cmd.scan_step) begin
      if (hit) begin
        res_r <= '{granted: GRANT_W'(ptr_r), status: ST_OK};
      end else if (last_step) begin
        res_r <= '{granted: '0, status: ST_FULL};
      end
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval && !bad && (req_r.operation == OP_FREE) && !hzero) begin
        used_r[hidx] <= 1'b0;
      end
      if (cmd.scan_step && hit) begin
        used_r[ptr_r] <= 1'b1;
        last_r        <= ptr_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/next_fit_handle_allocator_top.sv @@
// ----------------------------------------------------------------------------
// next_fit_handle_allocator_top
// Next-fit slot handle allocator over a bitmap of SLOTS used marks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes one request word:
//    operation (check/allocate or free) and an 8-bit handle.
//  - Result channel (out_valid/out_ready/out_data) returns one word per
//    request: granted handle and status (ok, out of slots, bad handle).
//  - One request is in flight at a time. in_ready is high only while the
//    sequencer is idle. For a check, a free or a bad handle, the result is
//    registered in EVAL and handed to the output register from DONE. An
//    allocation first runs the next-fit scan, which tests 1 to SLOTS-1 slots.
//    The scan tests one used mark per cycle. in_ready returns in the same
//    cycle that the result word appears in the output register.
//  - The output register decouples the sides: a new request is accepted
//    while the previous result word still waits on out_ready. If the
//    receiver stalls, the next result holds in the sequencer until the
//    output register frees up.
//  - Reset (rst_n low, synchronous) clears every used mark and the
//    last-grant pointer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module next_fit_handle_allocator_top import nfha_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  nfha_cmd_t  cmd;
  nfha_stat_t stat;

  // sequencer
  nfha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap, scan pointer, result path
  nfha_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one request at a time: an accept drops in_ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready held after accept");

  // failed requests never report a handle
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.granted == '0))
    else $error("nonzero handle with failing status");

  // a result word only appears when the sequencer hands one off
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result word without hand-off");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_BAD))
    else $error("undefined status code");

endmodule
